FILE: rtl/qrs_pkg.sv
package qrs_pkg;

  localparam logic [31:0] QNan = 32'h7FC00000;
  localparam int SqrtSteps = 25;
  localparam int DivSteps = 27;
  localparam int DivLanes = 2;

  typedef enum logic [1:0] {
    FP_NUM,
    FP_ZERO,
    FP_INF,
    FP_NAN
  } fp_class_e;

  // unnormalised value: mag[47] weighs 2^(expo-127)
  typedef struct packed {
    fp_class_e          cls;
    logic               sign;
    logic signed [11:0] expo;
    logic [47:0]        mag;
  } fp_raw_t;

  // normalised value ready for rounding: sig[26] is the leading one
  typedef struct packed {
    fp_class_e          cls;
    logic               sign;
    logic signed [11:0] expo;
    logic [26:0]        sig;
  } fp_norm_t;

  // normalised mantissa and unbiased exponent of a finite nonzero operand
  typedef struct packed {
    logic [23:0]        man;
    logic signed [11:0] expo;
  } fp_unp_t;

  typedef struct packed {
    logic [31:0] b;
    logic [31:0] a2;
    logic [31:0] c2;
    logic [31:0] nc;
    logic        lin;
    logic        neg;
    logic        bpos;
  } side_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'h0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'h0;
  endfunction

  function automatic logic [31:0] fscale2(input logic [31:0] x);
    logic [31:0] r;
    if (is_nan(x)) begin
      r = QNan;
    end else if (x[30:23] == 8'hFF) begin
      r = x;
    end else if (x[30:23] == 8'h00) begin
      r = {x[31], x[29:0], 1'b0};
    end else if (x[30:23] == 8'hFE) begin
      r = {x[31], 8'hFF, 23'h0};
    end else begin
      r = {x[31], x[30:23] + 8'd1, x[22:0]};
    end
    return r;
  endfunction

  function automatic logic signed [11:0] enc_exp(input logic [31:0] x);
    logic signed [11:0] e;
    if (x[30:23] == 8'h00) begin
      e = 12'sd1;
    end else begin
      e = $signed({4'b0, x[30:23]});
    end
    return e;
  endfunction

  function automatic fp_unp_t fp_unpack(input logic [31:0] x);
    fp_unp_t u;
    logic [23:0] m;
    logic [4:0] lz;
    logic found;
    m = {x[30:23] != 8'h00, x[22:0]};
    lz = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz = 5'(23 - i);
        found = 1'b1;
      end
    end
    u.man = m << lz;
    u.expo = enc_exp(x) - 12'sd127 - $signed({7'b0, lz});
    return u;
  endfunction

  function automatic fp_raw_t fmul_pre(input logic [31:0] x, input logic [31:0] y);
    fp_raw_t r;
    logic [23:0] mx;
    logic [23:0] my;
    mx = {x[30:23] != 8'h00, x[22:0]};
    my = {y[30:23] != 8'h00, y[22:0]};
    r.sign = x[31] ^ y[31];
    r.mag = mx * my;
    r.expo = enc_exp(x) + enc_exp(y) - 12'sd126;
    if (is_nan(x) || is_nan(y) || (is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y))) begin
      r.cls = FP_NAN;
    end else if (is_inf(x) || is_inf(y)) begin
      r.cls = FP_INF;
    end else if (is_zero(x) || is_zero(y)) begin
      r.cls = FP_ZERO;
    end else begin
      r.cls = FP_NUM;
    end
    return r;
  endfunction

  function automatic fp_raw_t fadd_pre(input logic [31:0] x, input logic [31:0] y);
    fp_raw_t r;
    logic [31:0] big;
    logic [31:0] sml;
    logic signed [11:0] eb;
    logic signed [11:0] d;
    logic [26:0] xa;
    logic [26:0] ya;
    logic [26:0] ys;
    logic [26:0] mask;
    logic [27:0] sum;
    if (x[30:0] >= y[30:0]) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end
    eb = enc_exp(big);
    d = eb - enc_exp(sml);
    xa = {big[30:23] != 8'h00, big[22:0], 3'b000};
    ya = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
    if (d > 12'sd26) begin
      ys = {26'h0, |ya};
    end else begin
      mask = ~(27'h7FFFFFF << d[4:0]);
      ys = ya >> d[4:0];
      ys[0] = ys[0] | (|(ya & mask));
    end
    if (big[31] ^ sml[31]) begin
      sum = {1'b0, xa} - {1'b0, ys};
    end else begin
      sum = {1'b0, xa} + {1'b0, ys};
    end
    r.mag = {sum, 20'h0};
    r.expo = eb + 12'sd1;
    r.sign = big[31];
    if (is_nan(x) || is_nan(y) || (is_inf(x) && is_inf(y) && (x[31] != y[31]))) begin
      r.cls = FP_NAN;
    end else if (is_inf(x)) begin
      r.cls = FP_INF;
      r.sign = x[31];
    end else if (is_inf(y)) begin
      r.cls = FP_INF;
      r.sign = y[31];
    end else if (sum == 28'h0) begin
      r.cls = FP_ZERO;
      r.sign = x[31] & y[31];
    end else begin
      r.cls = FP_NUM;
    end
    return r;
  endfunction

  function automatic fp_norm_t fnorm(input fp_raw_t r);
    fp_norm_t n;
    logic [5:0] lz;
    logic found;
    logic [47:0] m;
    lz = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && r.mag[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    m = r.mag << lz;
    n.sig = {m[47:22], |m[21:0]};
    n.expo = r.expo - $signed({6'b0, lz});
    n.sign = r.sign;
    if (r.cls == FP_NUM && !found) begin
      n.cls = FP_ZERO;
    end else begin
      n.cls = r.cls;
    end
    return n;
  endfunction

  function automatic logic [31:0] fround(input fp_norm_t n);
    logic [31:0] res;
    logic signed [11:0] shf;
    logic [4:0] sh;
    logic [26:0] s;
    logic [7:0] ef;
    logic inc;
    logic [30:0] body;
    shf = 12'sd1 - n.expo;
    sh = (shf > 12'sd27) ? 5'd27 : shf[4:0];
    if (n.expo < 12'sd1) begin
      s = n.sig >> sh;
      s[0] = s[0] | (|(n.sig & ~(27'h7FFFFFF << sh)));
      ef = 8'h00;
    end else begin
      s = n.sig;
      ef = n.expo[7:0];
    end
    inc = s[2] & (s[1] | s[0] | s[3]);
    body = {ef, s[25:3]} + {30'h0, inc};
    case (n.cls)
      FP_NAN:  res = QNan;
      FP_INF:  res = {n.sign, 8'hFF, 23'h0};
      FP_ZERO: res = {n.sign, 31'h0};
      default: begin
        if (n.expo > 12'sd254) begin
          res = {n.sign, 8'hFF, 23'h0};
        end else begin
          res = {n.sign, body};
        end
      end
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/quadratic_root_solver.sv
// throughput: one word per cycle; sqrt takes one root bit and each divider lane
// one quotient bit per pipeline stage, so every stage is busy on a different word
// a stall on the master side holds the whole pipeline in place
// reset clears the valid bits only; no state is kept between words
module quadratic_root_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // coef_a, coef_b, coef_c
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // first_root, second_root
  output logic [1:0]  m_axis_tuser_o    // no_real_roots, linear_case
);

  logic en;
  logic out_valid_q;

  logic [31:0] a_in;
  logic [31:0] b_in;
  logic [31:0] c_in;
  logic [31:0] a4;

  // products, discriminant and t stages
  logic [6:1] sv_q;
  logic [3:1] tv_q;

  qrs_pkg::fp_raw_t  [1:0] mul_q;
  qrs_pkg::fp_raw_t  [1:0] mul_d;
  qrs_pkg::fp_norm_t [1:0] mn_q;
  qrs_pkg::fp_norm_t [1:0] mn_d;
  logic [31:0] bb_q;
  logic [31:0] bb_d;
  logic [31:0] ac_q;
  logic [31:0] ac_d;
  qrs_pkg::fp_raw_t  add_q;
  qrs_pkg::fp_raw_t  add_d;
  qrs_pkg::fp_norm_t dn_q;
  qrs_pkg::fp_norm_t dn_d;
  logic [31:0] disc_q;
  logic [31:0] disc_d;
  qrs_pkg::side_t side_q [6:1];
  qrs_pkg::side_t side_d [6:1];

  logic sq_valid;
  logic [31:0] sq_root;
  qrs_pkg::side_t sq_side;

  qrs_pkg::fp_raw_t  tr_q;
  qrs_pkg::fp_raw_t  tr_d;
  qrs_pkg::fp_norm_t tn_q;
  qrs_pkg::fp_norm_t tn_d;
  logic [31:0] t_q;
  logic [31:0] t_d;
  qrs_pkg::side_t tside_q [3:1];
  logic [31:0] d_sel;

  logic [qrs_pkg::DivLanes-1:0][31:0] dv_num;
  logic [qrs_pkg::DivLanes-1:0][31:0] dv_den;
  logic dv_valid;
  logic [qrs_pkg::DivLanes-1:0][31:0] dv_quo;
  qrs_pkg::side_t dv_side;

  logic [63:0] out_data_q;
  logic [63:0] out_data_d;
  logic [1:0]  out_user_q;
  logic [1:0]  out_user_d;

  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign a_in = s_axis_tdata_i[31:0];
  assign b_in = s_axis_tdata_i[63:32];
  assign c_in = s_axis_tdata_i[95:64];

  always_comb begin
    a4 = qrs_pkg::fscale2(qrs_pkg::fscale2(a_in));
    mul_d[0] = qrs_pkg::fmul_pre(b_in, b_in);
    mul_d[1] = qrs_pkg::fmul_pre(a4, c_in);
    side_d[1].b = b_in;
    side_d[1].a2 = qrs_pkg::fscale2(a_in);
    side_d[1].c2 = qrs_pkg::fscale2(c_in);
    side_d[1].nc = {~c_in[31], c_in[30:0]};
    side_d[1].lin = qrs_pkg::is_zero(a_in);
    side_d[1].neg = 1'b0;
    side_d[1].bpos = !qrs_pkg::is_nan(b_in) && (!b_in[31] || qrs_pkg::is_zero(b_in));

    mn_d[0] = qrs_pkg::fnorm(mul_q[0]);
    mn_d[1] = qrs_pkg::fnorm(mul_q[1]);
    side_d[2] = side_q[1];

    bb_d = qrs_pkg::fround(mn_q[0]);
    ac_d = qrs_pkg::fround(mn_q[1]);
    side_d[3] = side_q[2];

    add_d = qrs_pkg::fadd_pre(bb_q, {~ac_q[31], ac_q[30:0]});
    side_d[4] = side_q[3];

    dn_d = qrs_pkg::fnorm(add_q);
    side_d[5] = side_q[4];

    disc_d = qrs_pkg::fround(dn_q);
    side_d[6] = side_q[5];
    side_d[6].neg = !side_q[5].lin && disc_d[31] && !qrs_pkg::is_zero(disc_d)
                    && !qrs_pkg::is_nan(disc_d);

    // -b - d when b is not negative, -b + d otherwise
    d_sel = sq_side.bpos ? {~sq_root[31], sq_root[30:0]} : sq_root;
    tr_d = qrs_pkg::fadd_pre({~sq_side.b[31], sq_side.b[30:0]}, d_sel);
    tn_d = qrs_pkg::fnorm(tr_q);
    t_d = qrs_pkg::fround(tn_q);

    dv_num[0] = tside_q[3].lin ? tside_q[3].nc : t_q;
    dv_den[0] = tside_q[3].lin ? tside_q[3].b : tside_q[3].a2;
    dv_num[1] = tside_q[3].c2;
    dv_den[1] = t_q;

    if (dv_side.lin || dv_side.bpos) begin
      out_data_d[31:0] = dv_quo[0];
    end else begin
      out_data_d[31:0] = dv_quo[1];
    end
    if (dv_side.lin || !dv_side.bpos) begin
      out_data_d[63:32] = dv_quo[0];
    end else begin
      out_data_d[63:32] = dv_quo[1];
    end
    out_user_d = {dv_side.lin, dv_side.neg};
  end

  qrs_fsqrt u_fsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[6]),
    .x_i     (disc_q),
    .side_i  (side_q[6]),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  qrs_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv_q[3]),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .side_i  (tside_q[3]),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      tv_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q <= {sv_q[5:1], s_axis_tvalid_i};
      tv_q <= {tv_q[2:1], sq_valid};
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q <= mul_d;
      mn_q <= mn_d;
      bb_q <= bb_d;
      ac_q <= ac_d;
      add_q <= add_d;
      dn_q <= dn_d;
      disc_q <= disc_d;
      for (int i = 1; i <= 6; i++) begin
        side_q[i] <= side_d[i];
      end
      tr_q <= tr_d;
      tn_q <= tn_d;
      t_q <= t_d;
      tside_q[1] <= sq_side;
      tside_q[2] <= tside_q[1];
      tside_q[3] <= tside_q[2];
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_user_q;

endmodule

FILE: rtl/qrs_fsqrt.sv
module qrs_fsqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      x_i,
  input  qrs_pkg::side_t   side_i,
  output logic             valid_o,
  output logic [31:0]      root_o,
  output qrs_pkg::side_t   side_o
);

  typedef struct packed {
    qrs_pkg::fp_class_e cls;
    logic               sign;
    logic signed [11:0] expo;
    logic [49:0]        rad;
    logic [27:0]        rem;
    logic [24:0]        root;
    qrs_pkg::side_t     side;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t o;
    logic [27:0] rem2;
    logic [27:0] trial;
    o = s;
    rem2 = {s.rem[25:0], s.rad[49:48]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[47:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem = rem2 - trial;
      o.root = {s.root[23:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.root = {s.root[23:0], 1'b0};
    end
    return o;
  endfunction

  sq_stage_t st_q [qrs_pkg::SqrtSteps+1];
  sq_stage_t st_d [qrs_pkg::SqrtSteps+1];
  logic [qrs_pkg::SqrtSteps:0] vld_q;
  logic out_valid_q;
  logic [31:0] root_q;
  logic [31:0] root_d;
  qrs_pkg::side_t side_q;

  qrs_pkg::fp_unp_t unp;
  logic signed [11:0] e_even;
  logic [24:0] man_adj;
  qrs_pkg::fp_norm_t fin;

  always_comb begin
    unp = qrs_pkg::fp_unpack(x_i);
    if (unp.expo[0]) begin
      man_adj = {unp.man, 1'b0};
      e_even = unp.expo - 12'sd1;
    end else begin
      man_adj = {1'b0, unp.man};
      e_even = unp.expo;
    end
    st_d[0].rad = {man_adj, 25'h0};
    st_d[0].rem = 28'h0;
    st_d[0].root = 25'h0;
    st_d[0].expo = (e_even >>> 1) + 12'sd127;
    st_d[0].sign = x_i[31];
    st_d[0].side = side_i;
    if (qrs_pkg::is_nan(x_i) || (x_i[31] && !qrs_pkg::is_zero(x_i))) begin
      st_d[0].cls = qrs_pkg::FP_NAN;
    end else if (qrs_pkg::is_inf(x_i)) begin
      st_d[0].cls = qrs_pkg::FP_INF;
    end else if (qrs_pkg::is_zero(x_i)) begin
      st_d[0].cls = qrs_pkg::FP_ZERO;
    end else begin
      st_d[0].cls = qrs_pkg::FP_NUM;
    end
    for (int i = 1; i <= qrs_pkg::SqrtSteps; i++) begin
      st_d[i] = sq_step(st_q[i-1]);
    end
    fin.cls = st_q[qrs_pkg::SqrtSteps].cls;
    fin.sign = st_q[qrs_pkg::SqrtSteps].sign;
    fin.expo = st_q[qrs_pkg::SqrtSteps].expo;
    fin.sig = {st_q[qrs_pkg::SqrtSteps].root, |st_q[qrs_pkg::SqrtSteps].rem, 1'b0};
    root_d = qrs_pkg::fround(fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[qrs_pkg::SqrtSteps-1:0], valid_i};
      out_valid_q <= vld_q[qrs_pkg::SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= qrs_pkg::SqrtSteps; i++) begin
        st_q[i] <= st_d[i];
      end
      root_q <= root_d;
      side_q <= st_q[qrs_pkg::SqrtSteps].side;
    end
  end

  assign valid_o = out_valid_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

FILE: rtl/qrs_fdiv.sv
module qrs_fdiv (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [qrs_pkg::DivLanes-1:0][31:0]    num_i,
  input  logic [qrs_pkg::DivLanes-1:0][31:0]    den_i,
  input  qrs_pkg::side_t                        side_i,
  output logic                                  valid_o,
  output logic [qrs_pkg::DivLanes-1:0][31:0]    quo_o,
  output qrs_pkg::side_t                        side_o
);

  typedef struct packed {
    qrs_pkg::fp_class_e cls;
    logic               sign;
    logic signed [11:0] expo;
    logic [25:0]        rem;
    logic [23:0]        den;
    logic [26:0]        quo;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t [qrs_pkg::DivLanes-1:0] lane;
    qrs_pkg::side_t                   side;
  } dv_stage_t;

  function automatic dv_lane_t dv_step(input dv_lane_t s);
    dv_lane_t o;
    logic [25:0] diff;
    o = s;
    diff = s.rem - {2'b00, s.den};
    if (s.rem >= {2'b00, s.den}) begin
      o.rem = {diff[24:0], 1'b0};
      o.quo = {s.quo[25:0], 1'b1};
    end else begin
      o.rem = {s.rem[24:0], 1'b0};
      o.quo = {s.quo[25:0], 1'b0};
    end
    return o;
  endfunction

  dv_stage_t st_q [qrs_pkg::DivSteps+1];
  dv_stage_t st_d [qrs_pkg::DivSteps+1];
  logic [qrs_pkg::DivSteps:0] vld_q;
  logic nrm_valid_q;
  logic out_valid_q;
  qrs_pkg::fp_norm_t [qrs_pkg::DivLanes-1:0] nrm_q;
  qrs_pkg::fp_norm_t [qrs_pkg::DivLanes-1:0] nrm_d;
  qrs_pkg::side_t nrm_side_q;
  logic [qrs_pkg::DivLanes-1:0][31:0] quo_q;
  logic [qrs_pkg::DivLanes-1:0][31:0] quo_d;
  qrs_pkg::side_t side_q;

  qrs_pkg::fp_unp_t [qrs_pkg::DivLanes-1:0] ux;
  qrs_pkg::fp_unp_t [qrs_pkg::DivLanes-1:0] uy;
  qrs_pkg::fp_raw_t [qrs_pkg::DivLanes-1:0] raw;

  always_comb begin
    st_d[0].side = side_i;
    for (int l = 0; l < qrs_pkg::DivLanes; l++) begin
      ux[l] = qrs_pkg::fp_unpack(num_i[l]);
      uy[l] = qrs_pkg::fp_unpack(den_i[l]);
      st_d[0].lane[l].sign = num_i[l][31] ^ den_i[l][31];
      st_d[0].lane[l].expo = ux[l].expo - uy[l].expo + 12'sd127;
      st_d[0].lane[l].rem = {2'b00, ux[l].man};
      st_d[0].lane[l].den = uy[l].man;
      st_d[0].lane[l].quo = 27'h0;
      if (qrs_pkg::is_nan(num_i[l]) || qrs_pkg::is_nan(den_i[l])
          || (qrs_pkg::is_zero(num_i[l]) && qrs_pkg::is_zero(den_i[l]))
          || (qrs_pkg::is_inf(num_i[l]) && qrs_pkg::is_inf(den_i[l]))) begin
        st_d[0].lane[l].cls = qrs_pkg::FP_NAN;
      end else if (qrs_pkg::is_inf(num_i[l]) || qrs_pkg::is_zero(den_i[l])) begin
        st_d[0].lane[l].cls = qrs_pkg::FP_INF;
      end else if (qrs_pkg::is_zero(num_i[l]) || qrs_pkg::is_inf(den_i[l])) begin
        st_d[0].lane[l].cls = qrs_pkg::FP_ZERO;
      end else begin
        st_d[0].lane[l].cls = qrs_pkg::FP_NUM;
      end
    end
    for (int i = 1; i <= qrs_pkg::DivSteps; i++) begin
      st_d[i].side = st_q[i-1].side;
      for (int l = 0; l < qrs_pkg::DivLanes; l++) begin
        st_d[i].lane[l] = dv_step(st_q[i-1].lane[l]);
      end
    end
    for (int l = 0; l < qrs_pkg::DivLanes; l++) begin
      raw[l].cls = st_q[qrs_pkg::DivSteps].lane[l].cls;
      raw[l].sign = st_q[qrs_pkg::DivSteps].lane[l].sign;
      raw[l].expo = st_q[qrs_pkg::DivSteps].lane[l].expo;
      raw[l].mag = {st_q[qrs_pkg::DivSteps].lane[l].quo, 20'h0,
                    st_q[qrs_pkg::DivSteps].lane[l].rem != 26'h0};
      nrm_d[l] = qrs_pkg::fnorm(raw[l]);
      quo_d[l] = qrs_pkg::fround(nrm_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      nrm_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[qrs_pkg::DivSteps-1:0], valid_i};
      nrm_valid_q <= vld_q[qrs_pkg::DivSteps];
      out_valid_q <= nrm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= qrs_pkg::DivSteps; i++) begin
        st_q[i] <= st_d[i];
      end
      nrm_q <= nrm_d;
      nrm_side_q <= st_q[qrs_pkg::DivSteps].side;
      quo_q <= quo_d;
      side_q <= nrm_side_q;
    end
  end

  assign valid_o = out_valid_q;
  assign quo_o = quo_q;
  assign side_o = side_q;

endmodule
